// ===== hw/rtl/malu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// malu_pkg: shared types and constants
// Action codes, part selectors and payload structs of the masked ALU.
// ----------------------------------------------------------------------------
package malu_pkg;

	localparam int WordW = 32;

	typedef enum logic [4:0] {
		ACT_MOV  = 5'd0,  ACT_ADD = 5'd1,  ACT_SUB = 5'd2,  ACT_SWAP = 5'd3,
		ACT_MUL  = 5'd4,  ACT_DIV = 5'd5,  ACT_CMP = 5'd6,  ACT_SHL  = 5'd7,
		ACT_SHR  = 5'd8,  ACT_AND = 5'd9,  ACT_OR  = 5'd10, ACT_XOR  = 5'd11,
		ACT_NOT  = 5'd12, ACT_JZ  = 5'd13, ACT_JP  = 5'd14, ACT_JN   = 5'd15,
		ACT_JNZ  = 5'd16, ACT_JNP = 5'd17, ACT_JNN = 5'd18, ACT_JMP  = 5'd19
	} action_t;

	localparam logic [1:0] PART_FULL = 2'd0;
	localparam logic [1:0] PART_LOB  = 2'd1;
	localparam logic [1:0] PART_HIB  = 2'd2;
	localparam logic [1:0] PART_LOH  = 2'd3;

	// Operand set carried down the pipe
	typedef struct packed {
		logic [4:0]       action;
		logic [WordW-1:0] dest_word;
		logic [1:0]       dest_part;
		logic [WordW-1:0] src_word;
		logic [1:0]       src_part;
		logic [WordW-1:0] acc_word;
		logic             n;
		logic             z;
		logic [WordW-1:0] a;
		logic [WordW-1:0] b;
	} op_t;

	// Result from the compute stages
	typedef struct packed {
		logic [WordW-1:0] r;
		logic [WordW-1:0] rem;
	} res_t;

	function automatic logic [WordW-1:0] part_mask(input logic [1:0] p);
		logic [WordW-1:0] m;
		case (p)
			PART_LOB: m = 32'h0000_00FF;
			PART_HIB: m = 32'h0000_FF00;
			PART_LOH: m = 32'h0000_FFFF;
			default:  m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

	function automatic logic [WordW-1:0] read_part(input logic [WordW-1:0] w,
		input logic [1:0] p);
		logic [WordW-1:0] r;
		r = w & part_mask(p);
		if (p == PART_HIB) r = r >> 8;
		return r;
	endfunction

	function automatic logic [WordW-1:0] write_part(input logic [WordW-1:0] w,
		input logic [WordW-1:0] v, input logic [1:0] p);
		logic [WordW-1:0] m;
		logic [WordW-1:0] vs;
		m = part_mask(p);
		vs = (p == PART_HIB) ? (v << 8) : v;
		return (w & ~m) | (vs & m);
	endfunction

endpackage

// ===== hw/rtl/masked_alu_with_condition_codes_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_alu_with_condition_codes_unit: masked ALU execute unit
// Operand part read, ALU and pipelined divider, masked write-back and flags.
// ----------------------------------------------------------------------------
// One instruction is accepted per cycle while the output is not stalled; each result
// passes through one register that reads the operand parts, the 32-stage divider
// that every item passes through and that keeps all results in order, and the output
// register that holds the result. The pipe advances whenever the output
// register is empty or being taken, so a stall holds every stage.
module masked_alu_with_condition_codes_unit
	import malu_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// action[4:0], dest_word[36:5], dest_part[38:37], src_word[70:39],
	// src_part[72:71], acc_word[104:73], flag_negative_in[105],
	// flag_zero_in[106], zero fill to 112
	input  logic [111:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// dest_new[31:0], src_new[63:32], acc_new[95:64], flag_negative_out[96],
	// flag_zero_out[97], take_jump[98], jump_target[114:99],
	// divide_error[115], zero fill to 120
	output logic [119:0] m_axis_tdata
);

	logic en;
	assign en            = ~m_axis_tvalid | m_axis_tready;
	assign s_axis_tready = en;

	// stage 1: capture and read parts
	logic v_s1;
	op_t  op_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1.action    <= s_axis_tdata[4:0];
			op_s1.dest_word <= s_axis_tdata[36:5];
			op_s1.dest_part <= s_axis_tdata[38:37];
			op_s1.src_word  <= s_axis_tdata[70:39];
			op_s1.src_part  <= s_axis_tdata[72:71];
			op_s1.acc_word  <= s_axis_tdata[104:73];
			op_s1.n         <= s_axis_tdata[105];
			op_s1.z         <= s_axis_tdata[106];
			op_s1.a         <= read_part(s_axis_tdata[36:5], s_axis_tdata[38:37]);
			op_s1.b         <= read_part(s_axis_tdata[70:39], s_axis_tdata[72:71]);
		end
	end

	logic             v_d;
	op_t              op_d;
	logic [WordW-1:0] quot, rem, r_alu;

	malu_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s1), .in_op(op_s1),
		.out_valid(v_d), .out_op(op_d), .quot(quot), .rem(rem)
	);

	malu_exec u_exec (
		.clk(clk), .en(en), .in_op(op_s1), .r(r_alu)
	);

	// final stage: write-back, flags, jumps
	logic [WordW-1:0] r, dnew, snew, anew;
	logic             nf, zf, jmp, isj, derr, wr, setf;
	always_comb begin
		r    = r_alu;
		dnew = op_d.dest_word;
		snew = op_d.src_word;
		anew = op_d.acc_word;
		nf   = op_d.n;
		zf   = op_d.z;
		jmp  = 1'b0;
		isj  = 1'b0;
		derr = 1'b0;
		wr   = 1'b0;
		setf = 1'b0;
		case (action_t'(op_d.action))
			ACT_MOV: wr = 1'b1;
			ACT_ADD, ACT_SUB, ACT_MUL, ACT_SHL, ACT_SHR,
			ACT_AND, ACT_OR, ACT_XOR, ACT_NOT: begin
				wr = 1'b1; setf = 1'b1;
			end
			ACT_CMP: setf = 1'b1;
			ACT_SWAP: begin
				dnew = write_part(op_d.dest_word, op_d.b, op_d.dest_part);
				snew = write_part(op_d.src_word, op_d.a, op_d.src_part);
			end
			ACT_DIV: begin
				if (op_d.b == '0) begin
					derr = 1'b1;
				end else begin
					r = quot; wr = 1'b1; setf = 1'b1;
					anew = write_part(op_d.acc_word, rem, op_d.dest_part);
				end
			end
			ACT_JZ:  begin isj = 1'b1; jmp = op_d.z; end
			ACT_JP:  begin isj = 1'b1; jmp = ~op_d.n & ~op_d.z; end
			ACT_JN:  begin isj = 1'b1; jmp = op_d.n & ~op_d.z; end
			ACT_JNZ: begin isj = 1'b1; jmp = ~op_d.z; end
			ACT_JNP: begin isj = 1'b1; jmp = op_d.n ^ op_d.z; end
			ACT_JNN: begin isj = 1'b1; jmp = ~op_d.n; end
			ACT_JMP: begin isj = 1'b1; jmp = 1'b1; end
			default: ;
		endcase
		if (wr) dnew = write_part(op_d.dest_word, r, op_d.dest_part);
		if (setf) begin
			nf = r[WordW-1];
			zf = (r == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= v_d;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {4'b0, derr, (isj ? op_d.a[15:0] : 16'h0), jmp, zf, nf,
				anew, snew, dnew};
		end
	end

endmodule

// ===== hw/rtl/malu_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// malu_div: pipelined signed divider
// Restoring division on magnitudes, one quotient bit per stage, 32 stages.
// The operand set travels alongside; quotient truncates toward zero.
// ----------------------------------------------------------------------------
module malu_div
	import malu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  op_t              in_op,
	output logic             out_valid,
	output op_t              out_op,
	output logic [WordW-1:0] quot,
	output logic [WordW-1:0] rem
);

	localparam int N = WordW;

	logic [N-1:0] a_mag, b_mag;
	assign a_mag = in_op.a[N-1] ? (~in_op.a + 1'b1) : in_op.a;
	assign b_mag = in_op.b[N-1] ? (~in_op.b + 1'b1) : in_op.b;

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic         v_in, qneg_in, rneg_in;
		op_t          op_in;
		logic [N-1:0] num_in, den_in, rem_in;
		logic [N:0]   trial;
		logic [N:0]   diff;
		logic         ge;
		logic         v_s, qneg_s, rneg_s;
		op_t          op_s;
		logic [N-1:0] num_s, den_s, rem_s;

		if (i == 0) begin : g_first
			assign v_in    = in_valid;
			assign op_in   = in_op;
			assign num_in  = a_mag;
			assign den_in  = b_mag;
			assign rem_in  = '0;
			assign qneg_in = in_op.a[N-1] ^ in_op.b[N-1];
			assign rneg_in = in_op.a[N-1];
		end else begin : g_next
			assign v_in    = g_stage[i-1].v_s;
			assign op_in   = g_stage[i-1].op_s;
			assign num_in  = g_stage[i-1].num_s;
			assign den_in  = g_stage[i-1].den_s;
			assign rem_in  = g_stage[i-1].rem_s;
			assign qneg_in = g_stage[i-1].qneg_s;
			assign rneg_in = g_stage[i-1].rneg_s;
		end

		assign trial = {rem_in, num_in[N-1]};
		assign diff  = trial - {1'b0, den_in};
		assign ge    = ~diff[N];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s <= 1'b0;
			end else if (en) begin
				v_s <= v_in;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				op_s   <= op_in;
				den_s  <= den_in;
				qneg_s <= qneg_in;
				rneg_s <= rneg_in;
				rem_s  <= ge ? diff[N-1:0] : trial[N-1:0];
				num_s  <= {num_in[N-2:0], ge};
			end
		end
	end

	logic [N-1:0] qm, rm;
	assign qm = g_stage[N-1].num_s;
	assign rm = g_stage[N-1].rem_s;
	assign quot      = g_stage[N-1].qneg_s ? (~qm + 1'b1) : qm;
	assign rem       = g_stage[N-1].rneg_s ? (~rm + 1'b1) : rm;
	assign out_valid = g_stage[N-1].v_s;
	assign out_op    = g_stage[N-1].op_s;

endmodule

// ===== hw/rtl/malu_exec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// malu_exec: arithmetic and logic stage
// Computes on the operand parts read in the first pipeline register, then
// delays the result through 32 registers to line up with the divider.
// ----------------------------------------------------------------------------
module malu_exec
	import malu_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  op_t              in_op,
	output logic [WordW-1:0] r
);

	localparam int Depth = WordW;

	logic [WordW-1:0] res;
	logic             big;
	logic [WordW-1:0] a, b;
	logic [4:0]       sh;

	assign a   = in_op.a;
	assign b   = in_op.b;
	assign big = |b[WordW-1:5];
	assign sh  = b[4:0];

	always_comb begin
		case (action_t'(in_op.action))
			ACT_MOV: res = b;
			ACT_ADD: res = a + b;
			ACT_SUB, ACT_CMP: res = a - b;
			ACT_MUL: res = a * b;
			ACT_SHL: res = big ? '0 : (a << sh);
			ACT_SHR: res = big ? {WordW{a[WordW-1]}} : WordW'($signed(a) >>> sh);
			ACT_AND: res = a & b;
			ACT_OR:  res = a | b;
			ACT_XOR: res = a ^ b;
			ACT_NOT: res = ~a;
			default: res = '0;
		endcase
	end

	// delay line to match divider latency
	logic [WordW-1:0] r_s [Depth];
	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0] <= res;
			for (int i = 1; i < Depth; i++) r_s[i] <= r_s[i-1];
		end
	end
	assign r = r_s[Depth-1];

endmodule

// ===== bench/malu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// malu_checker: result predictor and scoreboard for the masked ALU
// Watches both stream channels, computes the expected result of every input
// transfer and compares each output transfer with the oldest expectation.
// ----------------------------------------------------------------------------
module malu_checker
	import malu_pkg::*;
(
	input  logic         clk,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [111:0] s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [119:0] m_axis_tdata,
	output int           mismatches,
	output int           pending,
	output int           results_seen
);

	logic [119:0] expected_q[$];

	function automatic logic [31:0] field_mask(input logic [1:0] p);
		case (p)
			PART_LOB: return 32'h0000_00FF;
			PART_HIB: return 32'h0000_FF00;
			PART_LOH: return 32'h0000_FFFF;
			default:  return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic logic [31:0] get_field(input logic [31:0] w, input logic [1:0] p);
		logic [31:0] v;
		v = w & field_mask(p);
		if (p == PART_HIB) v = v >> 8;
		return v;
	endfunction

	function automatic logic [31:0] put_field(input logic [31:0] w, input logic [31:0] v,
		input logic [1:0] p);
		logic [31:0] sv;
		sv = (p == PART_HIB) ? {v[23:0], 8'h00} : v;
		return (w & ~field_mask(p)) | (sv & field_mask(p));
	endfunction

	function automatic logic [119:0] alu_outcome(input logic [111:0] d);
		logic [4:0] act;
		logic [31:0] dw, sw, aw, a, b, r, dn, sn, an;
		logic [1:0] dp, sp;
		logic n, z, jmp, isj, derr, wr, fl;
		longint sa, sb, q, rm;
		act = d[4:0]; dw = d[36:5]; dp = d[38:37]; sw = d[70:39]; sp = d[72:71];
		aw = d[104:73]; n = d[105]; z = d[106];
		a = get_field(dw, dp); b = get_field(sw, sp);
		r = '0; wr = 1'b0; fl = 1'b0; jmp = 1'b0; isj = 1'b0; derr = 1'b0;
		dn = dw; sn = sw; an = aw;
		case (act)
			ACT_MOV: begin r = b; wr = 1'b1; end
			ACT_ADD: begin r = a + b; wr = 1'b1; fl = 1'b1; end
			ACT_SUB: begin r = a - b; wr = 1'b1; fl = 1'b1; end
			ACT_SWAP: begin dn = put_field(dw, b, dp); sn = put_field(sw, a, sp); end
			ACT_MUL: begin r = a * b; wr = 1'b1; fl = 1'b1; end
			ACT_DIV: begin
				if (b == 0) derr = 1'b1;
				else begin
					sa = longint'($signed(a)); sb = longint'($signed(b));
					q = sa / sb; rm = sa % sb;
					r = q[31:0]; wr = 1'b1; fl = 1'b1;
					an = put_field(aw, rm[31:0], dp);
				end
			end
			ACT_CMP: begin r = a - b; fl = 1'b1; end
			ACT_SHL: begin r = (b >= 32) ? 32'd0 : a << b[4:0]; wr = 1'b1; fl = 1'b1; end
			ACT_SHR: begin
				r = (b >= 32) ? {32{a[31]}} : 32'($signed(a) >>> b[4:0]);
				wr = 1'b1; fl = 1'b1;
			end
			ACT_AND: begin r = a & b; wr = 1'b1; fl = 1'b1; end
			ACT_OR:  begin r = a | b; wr = 1'b1; fl = 1'b1; end
			ACT_XOR: begin r = a ^ b; wr = 1'b1; fl = 1'b1; end
			ACT_NOT: begin r = ~a; wr = 1'b1; fl = 1'b1; end
			ACT_JZ:  begin isj = 1'b1; jmp = z; end
			ACT_JP:  begin isj = 1'b1; jmp = !n && !z; end
			ACT_JN:  begin isj = 1'b1; jmp = n && !z; end
			ACT_JNZ: begin isj = 1'b1; jmp = !z; end
			ACT_JNP: begin isj = 1'b1; jmp = (z && !n) || (n && !z); end
			ACT_JNN: begin isj = 1'b1; jmp = !n; end
			ACT_JMP: begin isj = 1'b1; jmp = 1'b1; end
			default: ;
		endcase
		if (wr) dn = put_field(dw, r, dp);
		if (fl) begin n = r[31]; z = (r == 0); end
		return {4'd0, derr, isj ? a[15:0] : 16'd0, jmp, z, n, an, sn, dn};
	endfunction

	task automatic report(input string name, input logic [31:0] e, input logic [31:0] g);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t mismatch %s: expected %h got %h", $realtime, name, e, g);
	endtask

	initial begin
		mismatches = 0; pending = 0; results_seen = 0;
	end

	always @(posedge clk) begin
		logic [119:0] e;
		if (s_axis_tvalid && s_axis_tready)
			expected_q.push_back(alu_outcome(s_axis_tdata));
		if (m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("%0t result with nothing expected", $realtime);
			end else begin
				e = expected_q.pop_front();
				if (e[31:0] !== m_axis_tdata[31:0])
					report("dest_new", e[31:0], m_axis_tdata[31:0]);
				if (e[63:32] !== m_axis_tdata[63:32])
					report("src_new", e[63:32], m_axis_tdata[63:32]);
				if (e[95:64] !== m_axis_tdata[95:64])
					report("acc_new", e[95:64], m_axis_tdata[95:64]);
				if (e[96] !== m_axis_tdata[96])
					report("flag_negative_out", 32'(e[96]), 32'(m_axis_tdata[96]));
				if (e[97] !== m_axis_tdata[97])
					report("flag_zero_out", 32'(e[97]), 32'(m_axis_tdata[97]));
				if (e[98] !== m_axis_tdata[98])
					report("take_jump", 32'(e[98]), 32'(m_axis_tdata[98]));
				if (e[114:99] !== m_axis_tdata[114:99])
					report("jump_target", 32'(e[114:99]), 32'(m_axis_tdata[114:99]));
				if (e[115] !== m_axis_tdata[115])
					report("divide_error", 32'(e[115]), 32'(m_axis_tdata[115]));
			end
		end
		pending = expected_q.size();
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the masked ALU execute unit
// Drives directed corner instructions, then random ones with random gaps and
// back-pressure; the checker module predicts and scores every result.
// ----------------------------------------------------------------------------
module tb_top;
	import malu_pkg::*;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [111:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [119:0] m_axis_tdata;
	int           mismatches, pending, results_seen;
	int           sent = 0;
	bit           calm = 0;
	bit           hold_off = 0;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	masked_alu_with_condition_codes_unit uut (.*);

	malu_checker chk (
		.clk, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
		.mismatches, .pending, .results_seen
	);

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'd0;
			4: return $urandom_range(0, 40);
			5: return 32'hFFFF_FF00 | $urandom_range(0, 255);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [111:0] pack_instr(input logic [4:0] act,
		input logic [31:0] dw, input logic [1:0] dp, input logic [31:0] sw,
		input logic [1:0] sp, input logic [31:0] aw, input logic n, input logic z);
		return {5'd0, z, n, aw, sp, sw, dp, dw, act};
	endfunction

	// offer one instruction and wait for its transfer; valid stays up afterward
	task automatic send(input logic [111:0] d, input bit may_idle);
		while (may_idle && !calm && $urandom_range(0, 99) < 38) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	task automatic send_random();
		logic [4:0] act;
		act = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(20, 31))
			: 5'($urandom_range(0, 19));
		send(pack_instr(act, pick_word(), 2'($urandom), pick_word(), 2'($urandom),
			$urandom, 1'($urandom), 1'($urandom)), 1'b1);
	endtask

	// output side: random stalls, no stalls while calm, a long hold when asked
	always @(posedge clk) begin
		if (hold_off) m_axis_tready <= 0;
		else m_axis_tready <= calm || ($urandom_range(0, 99) >= 38);
	end

	initial begin
		#400000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int k;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: every action, all parts and flags, extremes
		for (k = 0; k < 20; k++)
			send(pack_instr(5'(k), 32'h8000_0000 | k, 2'(k), 32'hFFFF_FFFF, 2'(k + 1),
				32'h7FFF_FFFF, k[0], k[1]), 1'b0);
		send(pack_instr(ACT_DIV, 32'h8000_0000, PART_FULL, 32'hFFFF_FFFF, PART_FULL,
			32'h1234_5678, 1'b0, 1'b0), 1'b0);
		send(pack_instr(ACT_DIV, 32'h0000_0064, PART_FULL, 32'hFFFF_0000, PART_LOH,
			32'h1234_5678, 1'b1, 1'b0), 1'b0);
		send(pack_instr(ACT_SHL, 32'h0000_0001, PART_FULL, 32'd32, PART_FULL, 32'd0,
			1'b0, 1'b0), 1'b0);
		send(pack_instr(ACT_SHR, 32'h8000_0000, PART_FULL, 32'hFFFF_FFFF, PART_FULL, 32'd0,
			1'b0, 1'b1), 1'b0);
		send(pack_instr(ACT_SHR, 32'h8000_0000, PART_FULL, 32'd31, PART_FULL, 32'd0,
			1'b1, 1'b1), 1'b0);
		// receiver holds off for a long stretch while items keep coming
		fork
			begin
				hold_off = 1;
				repeat (120) @(posedge clk);
				hold_off = 0;
			end
			repeat (80) send_random();
		join
		// sender pauses until everything has come back
		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		// no-idle stretch
		calm = 1;
		repeat (150) send_random();
		calm = 0;
		repeat (700) send_random();
		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (60) @(posedge clk);
		$display("Sent %0d instructions covering all actions, parts, flags and corners;",
			sent);
		$display("received %0d results with %0d mismatches.", results_seen, mismatches);
		if (mismatches == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/malu_pkg.sv
hw/rtl/malu_div.sv
hw/rtl/malu_exec.sv
hw/rtl/masked_alu_with_condition_codes_unit.sv
bench/malu_checker.sv
bench/tb_top.sv
